[rtl/pmrd_pkg.sv]
// ----------------------------------------------------------------------------
// pmrd_pkg
// shared types and constants of the pid unit with derivative on measured rate
// ----------------------------------------------------------------------------
package pmrd_pkg;

    localparam int DATA_W  = 32;
    localparam int LIM_W   = 31;
    localparam int CFG_IDX_W = 3;
    localparam int DIV_STEPS = 32;
    localparam int CNT_W   = $clog2(DIV_STEPS);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_KP      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KI      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KD      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DB      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ILOW    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_IHIGH   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_ILIMIT  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_OLIMIT  = 3'd7;

    typedef enum logic [4:0] {
        OP_NOP,
        OP_LOAD,
        OP_ERR,
        OP_TRAP,
        OP_MUL_W,
        OP_DIV,
        OP_QUOT,
        OP_MUL_KI,
        OP_MUL_TLO,
        OP_MUL_THI,
        OP_RSCALE,
        OP_ACC,
        OP_MUL_P,
        OP_ADD_P,
        OP_MUL_D,
        OP_ADD_D,
        OP_OUT,
        OP_OUT_DEAD
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic dead;
        logic integ;
        logic full;
    } dp_status_t;

endpackage

[rtl/pmrd_if.sv]
// ----------------------------------------------------------------------------
// pmrd channel interfaces
// valid/ready channels for the input sample and the controller result
// ----------------------------------------------------------------------------
interface pmrd_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] measured;
    logic signed [31:0] target;
    logic signed [31:0] measured_rate;
    logic        [31:0] elapsed_time;

    modport source (output valid, output measured, output target,
                    output measured_rate, output elapsed_time, input ready);
    modport sink   (input valid, input measured, input target,
                    input measured_rate, input elapsed_time, output ready);
endinterface

interface pmrd_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] drive;
    logic               in_dead_band;
    logic               integral_clamped;
    logic               output_clamped;

    modport source (output valid, output drive, output in_dead_band,
                    output integral_clamped, output output_clamped, input ready);
    modport sink   (input valid, input drive, input in_dead_band,
                    input integral_clamped, input output_clamped, output ready);
endinterface

[rtl/pmrd_datapath.sv]
// ----------------------------------------------------------------------------
// pmrd_datapath
// config registers, loop state, shared 32x32 multiplier and serial divider
// ----------------------------------------------------------------------------
module pmrd_datapath
    import pmrd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [DATA_W-1:0]     cfg_data,
    input  dp_cmd_t               cmd,
    output dp_status_t            status,
    input  logic signed [31:0]    measured,
    input  logic signed [31:0]    target,
    input  logic signed [31:0]    measured_rate,
    input  logic        [31:0]    elapsed_time,
    output logic signed [31:0]    drive,
    output logic                  in_dead_band,
    output logic                  integral_clamped,
    output logic                  output_clamped
);

    localparam int SUM_W = 50;
    localparam int R_W   = 57;
    localparam int ACC_W = 58;

    function automatic logic [31:0] abs32(input logic [31:0] v);
        abs32 = v[31] ? (32'd0 - v) : v;
    endfunction

    // configuration
    logic signed [31:0] kp_reg, ki_reg, kd_reg;
    logic [LIM_W-1:0]   db_reg, ilow_reg, ihigh_reg, ilim_reg, olim_reg;

    // loop state
    logic signed [31:0] previous_error_reg;
    logic signed [31:0] integral_sum_reg;

    // working registers
    logic signed [31:0] meas_reg, tgt_reg, rate_reg;
    logic [31:0]        dt_reg;
    logic signed [31:0] e_reg;
    logic [31:0]        ae_reg;
    logic [31:0]        half_mag_reg;
    logic [31:0]        iterm_mag_reg;
    logic               iterm_neg_reg;
    logic [63:0]        prod_reg;
    logic [31:0]        rem_reg;
    logic [63:0]        m_reg;
    logic               mneg_reg;
    logic signed [R_W-1:0]   r_reg;
    logic                    iclamp_reg;
    logic                    term_neg_reg;
    logic signed [SUM_W-1:0] sum_reg;

    // result registers
    logic signed [31:0] drive_reg;
    logic               dead_out_reg, iclamp_out_reg, oclamp_out_reg;

    // error
    logic signed [32:0] diff;
    logic signed [31:0] e_sat;

    // trapezoid
    logic signed [33:0] s_val;
    logic [33:0]        s_abs;
    logic [32:0]        h_mag;
    logic [32:0]        h_lim;
    logic [31:0]        half_mag;

    // multiplier
    logic [31:0] mul_a, mul_b;
    logic [63:0] product;

    // divider
    logic [LIM_W-1:0] span;
    logic [31:0]      rem_shift;
    logic             q_bit;

    // accumulate and sum
    logic [63:0]              r_sum;
    logic [R_W-2:0]           r_mag;
    logic signed [ACC_W-1:0]  acc;
    logic signed [ACC_W-1:0]  ilim_s;
    logic signed [ACC_W-1:0]  acc_cl;
    logic                     acc_hit;
    logic [47:0]              term_mag;
    logic signed [SUM_W-1:0]  term_s;
    logic signed [SUM_W-1:0]  olim_s;
    logic signed [SUM_W-1:0]  sum_cl;
    logic                     sum_hit;

    assign diff = {tgt_reg[31], tgt_reg} - {meas_reg[31], meas_reg};

    always_comb
    begin
        if (diff[32] != diff[31])
            e_sat = diff[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        else
            e_sat = diff[31:0];
    end

    always_comb
    begin
        status.dead  = (ae_reg < {1'b0, db_reg});
        status.full  = (ae_reg < {1'b0, ilow_reg});
        status.integ = (ae_reg < {1'b0, ihigh_reg}) || status.full;
    end

    // dead band taken off toward zero, zero error counts as negative
    always_comb
    begin
        s_val = {{2{e_reg[31]}}, e_reg} + {{2{previous_error_reg[31]}}, previous_error_reg};
        if (e_reg[31] || (e_reg == 32'sd0))
            s_val = s_val + {3'b000, db_reg};
        else
            s_val = s_val - {3'b000, db_reg};
        s_abs = s_val[33] ? (34'd0 - s_val) : s_val;
        h_mag = s_abs[33:1];
        h_lim = s_val[33] ? 33'h0_8000_0000 : 33'h0_7fff_ffff;
        half_mag = (h_mag > h_lim) ? h_lim[31:0] : h_mag[31:0];
    end

    always_comb
    begin
        case (cmd.op)
            OP_MUL_W:
            begin
                mul_a = half_mag_reg;
                mul_b = ae_reg - {1'b0, ilow_reg};
            end
            OP_MUL_KI:
            begin
                mul_a = iterm_mag_reg;
                mul_b = abs32(ki_reg);
            end
            OP_MUL_TLO:
            begin
                mul_a = m_reg[31:0];
                mul_b = dt_reg;
            end
            OP_MUL_THI:
            begin
                mul_a = m_reg[63:32];
                mul_b = dt_reg;
            end
            OP_MUL_P:
            begin
                mul_a = abs32(kp_reg);
                mul_b = ae_reg;
            end
            OP_MUL_D:
            begin
                mul_a = abs32(kd_reg);
                mul_b = abs32(rate_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign product = {32'd0, mul_a} * {32'd0, mul_b};

    // one quotient bit per step, remainder stays below the span
    assign span      = ihigh_reg - ilow_reg;
    assign rem_shift = {rem_reg[30:0], prod_reg[31]};
    assign q_bit     = (rem_shift >= {1'b0, span});

    assign r_sum = prod_reg + {32'd0, rem_reg};
    assign r_mag = r_sum[63:8];

    always_comb
    begin
        acc    = {{(ACC_W-32){integral_sum_reg[31]}}, integral_sum_reg}
               + {r_reg[R_W-1], r_reg};
        ilim_s = {{(ACC_W-LIM_W){1'b0}}, ilim_reg};
        acc_cl  = acc;
        acc_hit = 1'b0;
        if (acc > ilim_s)
        begin
            acc_cl  = ilim_s;
            acc_hit = 1'b1;
        end
        else if (acc < -ilim_s)
        begin
            acc_cl  = -ilim_s;
            acc_hit = 1'b1;
        end
    end

    always_comb
    begin
        term_mag = prod_reg[63:16];
        if (term_neg_reg)
            term_s = -$signed({{(SUM_W-48){1'b0}}, term_mag});
        else
            term_s = $signed({{(SUM_W-48){1'b0}}, term_mag});
        olim_s  = {{(SUM_W-LIM_W){1'b0}}, olim_reg};
        sum_cl  = sum_reg;
        sum_hit = 1'b0;
        if (sum_reg > olim_s)
        begin
            sum_cl  = olim_s;
            sum_hit = 1'b1;
        end
        else if (sum_reg < -olim_s)
        begin
            sum_cl  = -olim_s;
            sum_hit = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp_reg    <= '0;
            ki_reg    <= '0;
            kd_reg    <= '0;
            db_reg    <= '0;
            ilow_reg  <= '0;
            ihigh_reg <= '0;
            ilim_reg  <= '0;
            olim_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_KP:     kp_reg    <= cfg_data;
                CFG_KI:     ki_reg    <= cfg_data;
                CFG_KD:     kd_reg    <= cfg_data;
                CFG_DB:     db_reg    <= cfg_data[LIM_W-1:0];
                CFG_ILOW:   ilow_reg  <= cfg_data[LIM_W-1:0];
                CFG_IHIGH:  ihigh_reg <= cfg_data[LIM_W-1:0];
                CFG_ILIMIT: ilim_reg  <= cfg_data[LIM_W-1:0];
                CFG_OLIMIT: olim_reg  <= cfg_data[LIM_W-1:0];
                default:    kp_reg    <= kp_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            previous_error_reg <= '0;
            integral_sum_reg   <= '0;
        end
        else
        begin
            case (cmd.op)
                OP_ACC:      integral_sum_reg   <= acc_cl[31:0];
                OP_OUT_DEAD: integral_sum_reg   <= '0;
                OP_OUT:      previous_error_reg <= e_reg;
                default:     previous_error_reg <= previous_error_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD:
            begin
                meas_reg <= measured;
                tgt_reg  <= target;
                rate_reg <= measured_rate;
                dt_reg   <= elapsed_time;
            end
            OP_ERR:
            begin
                e_reg  <= e_sat;
                ae_reg <= abs32(e_sat);
            end
            OP_TRAP:
            begin
                half_mag_reg  <= half_mag;
                iterm_neg_reg <= s_val[33];
                iterm_mag_reg <= status.full ? half_mag : 32'd0;
            end
            OP_MUL_W:
            begin
                prod_reg <= product;
                rem_reg  <= product[63:32];
            end
            OP_DIV:
            begin
                rem_reg        <= q_bit ? (rem_shift - {1'b0, span}) : rem_shift;
                prod_reg[31:0] <= {prod_reg[30:0], q_bit};
            end
            OP_QUOT:
                iterm_mag_reg <= prod_reg[31:0];
            OP_MUL_KI:
            begin
                m_reg    <= product;
                mneg_reg <= iterm_neg_reg ^ ki_reg[31];
            end
            OP_MUL_TLO:
                prod_reg <= product;
            OP_MUL_THI:
            begin
                prod_reg <= product;
                rem_reg  <= prod_reg[63:32];
            end
            OP_RSCALE:
                r_reg <= mneg_reg ? -$signed({1'b0, r_mag}) : $signed({1'b0, r_mag});
            OP_ACC:
            begin
                iclamp_reg <= acc_hit;
                sum_reg    <= {{(SUM_W-32){acc_cl[31]}}, acc_cl[31:0]};
            end
            OP_MUL_P:
            begin
                prod_reg     <= product;
                term_neg_reg <= kp_reg[31] ^ e_reg[31];
            end
            OP_MUL_D:
            begin
                prod_reg     <= product;
                term_neg_reg <= kd_reg[31] ^ rate_reg[31];
            end
            OP_ADD_P, OP_ADD_D:
                sum_reg <= sum_reg + term_s;
            OP_OUT:
            begin
                drive_reg      <= sum_cl[31:0];
                dead_out_reg   <= 1'b0;
                iclamp_out_reg <= iclamp_reg;
                oclamp_out_reg <= sum_hit;
            end
            OP_OUT_DEAD:
            begin
                drive_reg      <= '0;
                dead_out_reg   <= 1'b1;
                iclamp_out_reg <= 1'b0;
                oclamp_out_reg <= 1'b0;
            end
            default:
                dt_reg <= dt_reg;
        endcase
    end

    assign drive            = drive_reg;
    assign in_dead_band     = dead_out_reg;
    assign integral_clamped = iclamp_out_reg;
    assign output_clamped   = oclamp_out_reg;

endmodule

[rtl/pmrd_ctrl.sv]
// ----------------------------------------------------------------------------
// pmrd_ctrl
// sequencer for one controller step, output valid register
// ----------------------------------------------------------------------------
module pmrd_ctrl
    import pmrd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    typedef enum logic [4:0] {
        S_IDLE,
        S_ERR,
        S_TRAP,
        S_MUL_W,
        S_DIV,
        S_QUOT,
        S_MUL_KI,
        S_MUL_TLO,
        S_MUL_THI,
        S_RSCALE,
        S_ACC,
        S_MUL_P,
        S_ADD_P,
        S_MUL_D,
        S_ADD_D,
        S_FIN,
        S_FIN_DEAD
    } state_t;

    state_t           state_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             slot_free;

    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    // result held until its transfer, raised when a finish step issues
    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        if ((state_reg == S_FIN || state_reg == S_FIN_DEAD) && slot_free)
            out_valid_next = 1'b1;
    end

    always_comb
    begin
        unique case (state_reg)
            S_IDLE:     cmd.op = in_valid ? OP_LOAD : OP_NOP;
            S_ERR:      cmd.op = OP_ERR;
            S_TRAP:     cmd.op = OP_TRAP;
            S_MUL_W:    cmd.op = OP_MUL_W;
            S_DIV:      cmd.op = OP_DIV;
            S_QUOT:     cmd.op = OP_QUOT;
            S_MUL_KI:   cmd.op = OP_MUL_KI;
            S_MUL_TLO:  cmd.op = OP_MUL_TLO;
            S_MUL_THI:  cmd.op = OP_MUL_THI;
            S_RSCALE:   cmd.op = OP_RSCALE;
            S_ACC:      cmd.op = OP_ACC;
            S_MUL_P:    cmd.op = OP_MUL_P;
            S_ADD_P:    cmd.op = OP_ADD_P;
            S_MUL_D:    cmd.op = OP_MUL_D;
            S_ADD_D:    cmd.op = OP_ADD_D;
            S_FIN:      cmd.op = slot_free ? OP_OUT : OP_NOP;
            S_FIN_DEAD: cmd.op = slot_free ? OP_OUT_DEAD : OP_NOP;
            default:    cmd.op = OP_NOP;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            unique case (state_reg)
                S_IDLE:
                    if (in_valid)
                        state_reg <= S_ERR;
                S_ERR:
                    state_reg <= S_TRAP;
                S_TRAP:
                begin
                    if (status.dead)
                        state_reg <= S_FIN_DEAD;
                    else if (status.integ && !status.full)
                        state_reg <= S_MUL_W;
                    else
                        state_reg <= S_MUL_KI;
                end
                S_MUL_W:
                begin
                    cnt_reg   <= CNT_W'(DIV_STEPS - 1);
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == '0)
                        state_reg <= S_QUOT;
                end
                S_QUOT:    state_reg <= S_MUL_KI;
                S_MUL_KI:  state_reg <= S_MUL_TLO;
                S_MUL_TLO: state_reg <= S_MUL_THI;
                S_MUL_THI: state_reg <= S_RSCALE;
                S_RSCALE:  state_reg <= S_ACC;
                S_ACC:     state_reg <= S_MUL_P;
                S_MUL_P:   state_reg <= S_ADD_P;
                S_ADD_P:   state_reg <= S_MUL_D;
                S_MUL_D:   state_reg <= S_ADD_D;
                S_ADD_D:   state_reg <= S_FIN;
                S_FIN, S_FIN_DEAD:
                begin
                    if (slot_free)
                        state_reg <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == S_ERR))
        else $error("accepted sample did not start a step");

    a_valid_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |->
            ($past(state_reg) == S_FIN || $past(state_reg) == S_FIN_DEAD))
        else $error("result valid raised outside a finish state");

    a_quot_after_div: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_QUOT) |-> ($past(state_reg) == S_DIV && cnt_reg == '1))
        else $error("quotient taken before divide finished");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |-> (cmd.op != OP_OUT && cmd.op != OP_OUT_DEAD))
        else $error("pending result overwritten");
`endif

endmodule

[rtl/pid_measured_rate_derivative_unit.sv]
// ----------------------------------------------------------------------------
// pid_measured_rate_derivative_unit
// a new sample is accepted only while idle, once the previous step is done;
//   the step is shortest inside the dead band and longest when the error lies
//   between the integral thresholds (32-step serial divide for the weight)
// the step length is set by the shared multiplier and the divider; a waiting
//   result stalls only the finish step
// reset: rst_n async low clears config registers, previous error and integral
// ----------------------------------------------------------------------------
module pid_measured_rate_derivative_unit
    import pmrd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    pmrd_in_if.sink              in_ch,
    pmrd_out_if.source           out_ch,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DATA_W-1:0]    cfg_data
);

    // command and status between sequencer and datapath
    dp_cmd_t    cmd;
    dp_status_t status;

    // sequencer: input ready while idle, result valid held until its transfer
    pmrd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .status    (status),
        .cmd       (cmd)
    );

    // datapath: error, trapezoid integral, gain products, clamps
    pmrd_datapath u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .cmd              (cmd),
        .status           (status),
        .measured         (in_ch.measured),
        .target           (in_ch.target),
        .measured_rate    (in_ch.measured_rate),
        .elapsed_time     (in_ch.elapsed_time),
        .drive            (out_ch.drive),
        .in_dead_band     (out_ch.in_dead_band),
        .integral_clamped (out_ch.integral_clamped),
        .output_clamped   (out_ch.output_clamped)
    );

endmodule
